[src/websocket_frame_decoder_assert.svh]
// Assertion macros used by the checker file of the frame decoder.
// Every check is clocked on clock and switched off while reset is high.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the condition.
`define WSFD_ASSERT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// The consequent must hold in the cycle after the condition.
`define WSFD_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[src/wsfd_pkg.sv]
`timescale 1ns / 1ps

package wsfd_pkg;

   localparam int unsigned LenW = 63;
   localparam logic [LenW-1:0] MaxLenReset = 63'd67108864;

   localparam logic [6:0] Len16Code   = 7'd126;
   localparam logic [6:0] Len64Code   = 7'd127;
   localparam logic [3:0] Ext16Bytes  = 4'd2;
   localparam logic [3:0] Ext64Bytes  = 4'd8;
   localparam logic [3:0] KeyBytes    = 4'd4;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_DATA,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_LEN_TOP    = 2'd0,
      ERR_UNMASKED   = 2'd1,
      ERR_OVER_LIMIT = 2'd2
   } err_type;

   typedef struct packed {
      kind_type        kind;
      logic            fin;
      logic [3:0]      opcode;
      logic [LenW-1:0] length;
      logic [7:0]      payload;
      err_type         err;
      logic            last;
   } result_type;

endpackage

[src/wsfd_parser.sv]
`timescale 1ns / 1ps

module wsfd_parser import wsfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      in_byte,
   input  logic [LenW-1:0] max_len,
   output logic            push,
   output result_type      result
);

   phase_type       phase_ff, phase_in;
   logic [3:0]      field_count_ff, field_count_in;
   logic            fin_ff, fin_in;
   logic [3:0]      opcode_ff, opcode_in;
   logic            mask_flag_ff, mask_flag_in;
   logic [63:0]     length_ff, length_in;
   logic [31:0]     key_ff, key_in;
   logic [LenW-1:0] left_ff, left_in;
   logic [1:0]      key_pos_ff, key_pos_in;

   logic [63:0]     len_check;
   logic            mask_check;
   logic            err_top;
   logic            over_limit;
   logic            check_fail;
   err_type         err_code;
   logic [3:0]      count_dec;
   logic [3:0]      count_inc;
   logic [LenW-1:0] left_dec;
   logic [7:0]      key_byte;
   logic            is_ext_code;

   // The length check runs on the byte that completes the length field.
   always_comb begin
      if (phase_ff == PH_EXT) begin
         len_check  = {length_ff[55:0], in_byte};
         mask_check = mask_flag_ff;
      end else begin
         len_check  = {57'd0, in_byte[6:0]};
         mask_check = in_byte[7];
      end
      err_top    = (phase_ff == PH_EXT) && len_check[63];
      over_limit = len_check > {1'b0, max_len};
      check_fail = err_top || !mask_check || over_limit;
      priority if (err_top) begin
         err_code = ERR_LEN_TOP;
      end else if (!mask_check) begin
         err_code = ERR_UNMASKED;
      end else begin
         err_code = ERR_OVER_LIMIT;
      end
      count_dec   = field_count_ff - 4'd1;
      count_inc   = field_count_ff + 4'd1;
      left_dec    = left_ff - {{(LenW-1){1'b0}}, 1'b1};
      is_ext_code = (in_byte[6:0] == Len16Code) || (in_byte[6:0] == Len64Code);
      unique case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR1: begin
               if (is_ext_code) begin
                  phase_in = PH_EXT;
               end else begin
                  phase_in = check_fail ? PH_HALT : PH_KEY;
               end
            end
            PH_EXT: begin
               if (count_dec == 4'd0) begin
                  phase_in = check_fail ? PH_HALT : PH_KEY;
               end
            end
            PH_KEY: begin
               if (count_inc == KeyBytes) begin
                  phase_in = (length_ff[LenW-1:0] == '0) ? PH_HDR0 : PH_DATA;
               end
            end
            PH_DATA: begin
               if (left_dec == '0) begin
                  phase_in = PH_HDR0;
               end
            end
            PH_HALT: phase_in = PH_HALT;
            default: phase_in = PH_HDR1;
         endcase
      end
   end

   // Held fields and the result item.
   always_comb begin
      field_count_in = field_count_ff;
      fin_in         = fin_ff;
      opcode_in      = opcode_ff;
      mask_flag_in   = mask_flag_ff;
      length_in      = length_ff;
      key_in         = key_ff;
      left_in        = left_ff;
      key_pos_in     = key_pos_ff;
      push           = 1'b0;
      result.kind    = KIND_HEADER;
      result.fin     = fin_ff;
      result.opcode  = opcode_ff;
      result.length  = length_ff[LenW-1:0];
      result.payload = 8'd0;
      result.err     = ERR_LEN_TOP;
      result.last    = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR1: begin
               mask_flag_in = in_byte[7];
               if (is_ext_code) begin
                  length_in      = 64'd0;
                  field_count_in = (in_byte[6:0] == Len16Code) ? Ext16Bytes : Ext64Bytes;
               end else begin
                  length_in      = len_check;
                  field_count_in = 4'd0;
                  if (check_fail) begin
                     push          = 1'b1;
                     result.kind   = KIND_ERROR;
                     result.length = len_check[LenW-1:0];
                     result.err    = err_code;
                     result.last   = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               length_in      = len_check;
               field_count_in = count_dec;
               if (count_dec == 4'd0 && check_fail) begin
                  push          = 1'b1;
                  result.kind   = KIND_ERROR;
                  result.length = len_check[LenW-1:0];
                  result.err    = err_code;
                  result.last   = 1'b1;
               end
            end
            PH_KEY: begin
               key_in         = {key_ff[23:0], in_byte};
               field_count_in = count_inc;
               if (count_inc == KeyBytes) begin
                  field_count_in = 4'd0;
                  key_pos_in     = 2'd0;
                  left_in        = length_ff[LenW-1:0];
                  push           = 1'b1;
                  result.kind    = KIND_HEADER;
                  result.last    = (length_ff[LenW-1:0] == '0);
               end
            end
            PH_DATA: begin
               key_pos_in     = key_pos_ff + 2'd1;
               left_in        = left_dec;
               push           = 1'b1;
               result.kind    = KIND_PAYLOAD;
               result.payload = in_byte ^ key_byte;
               result.last    = (left_dec == '0);
            end
            PH_HALT: begin
            end
            default: begin
               fin_in    = in_byte[7];
               opcode_in = in_byte[3:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR0;
         field_count_ff <= 4'd0;
         fin_ff         <= 1'b0;
         opcode_ff      <= 4'd0;
         mask_flag_ff   <= 1'b0;
         length_ff      <= 64'd0;
         key_ff         <= 32'd0;
         left_ff        <= '0;
         key_pos_ff     <= 2'd0;
      end else begin
         phase_ff       <= phase_in;
         field_count_ff <= field_count_in;
         fin_ff         <= fin_in;
         opcode_ff      <= opcode_in;
         mask_flag_ff   <= mask_flag_in;
         length_ff      <= length_in;
         key_ff         <= key_in;
         left_ff        <= left_in;
         key_pos_ff     <= key_pos_in;
      end
   end

endmodule

[src/wsfd_outbuf.sv]
`timescale 1ns / 1ps

module wsfd_outbuf import wsfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       out_stall,
   output logic       out_valid,
   output result_type out_data,
   output logic       full
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       take;

   // The skid entry only fills when the output entry is held by a stall.
   always_comb begin
      take          = main_valid_ff && !out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push;
         main_in       = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign full      = skid_valid_ff;

endmodule

[src/websocket_frame_decoder.sv]
`timescale 1ns / 1ps
// A result item is registered in the output buffer before it appears on the rsp_ ports.
// Throughput: one byte per cycle; req_stall rises only while the two-entry output buffer is full.
// Reset (synchronous, active high): the parser waits for a first header byte, the buffer
// is empty, and the payload limit returns to 64 MiB. No clearing pass is needed.
module websocket_frame_decoder import wsfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_in_byte,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_result_kind,
   output logic            rsp_frame_final,
   output logic [3:0]      rsp_frame_opcode,
   output logic [LenW-1:0] rsp_frame_length,
   output logic [7:0]      rsp_payload_byte,
   output logic [1:0]      rsp_error_code,
   output logic            rsp_last_of_frame,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [LenW-1:0] csr_max_payload_length
);

   logic [LenW-1:0] max_len_ff, max_len_in;
   logic            accept;
   logic            push;
   logic            buf_full;
   result_type      parsed;
   result_type      out_item;

   // The limit register takes a write in any cycle; the user must write only while idle (not enforced).
   assign csr_ready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_valid && csr_ready) begin
         max_len_in = csr_max_payload_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // An item is taken whenever the skid entry is free, so the stall seen upstream
   // comes straight from a register and never from rsp_stall in the same cycle.
   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   // The parser handles one byte per cycle while req_stall is low: header fields, extended length,
   // mask key, then payload unmasking, with the frame checks on the last length byte.
   wsfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .max_len (max_len_ff),
      .push    (push),
      .result  (parsed)
   );

   // Output register plus skid entry, so one stalled result does not block the next byte.
   wsfd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (parsed),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_item),
      .full      (buf_full)
   );

   assign rsp_result_kind   = out_item.kind;
   assign rsp_frame_final   = out_item.fin;
   assign rsp_frame_opcode  = out_item.opcode;
   assign rsp_frame_length  = out_item.length;
   assign rsp_payload_byte  = out_item.payload;
   assign rsp_error_code    = out_item.err;
   assign rsp_last_of_frame = out_item.last;

endmodule

[src/wsfd_checker.sv]
`timescale 1ns / 1ps
`include "websocket_frame_decoder_assert.svh"

module wsfd_checker import wsfd_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic [7:0]      req_in_byte,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input logic [1:0]      rsp_result_kind,
   input logic            rsp_frame_final,
   input logic [3:0]      rsp_frame_opcode,
   input logic [LenW-1:0] rsp_frame_length,
   input logic [7:0]      rsp_payload_byte,
   input logic [1:0]      rsp_error_code,
   input logic            rsp_last_of_frame,
   input logic            csr_valid,
   input logic            csr_ready,
   input logic [LenW-1:0] csr_max_payload_length
);

   `WSFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_payload_byte) && $stable(rsp_frame_length) && $stable(rsp_last_of_frame), "stalled result changed")

   `WSFD_ASSERT(a_error_last, rsp_valid && rsp_result_kind == KIND_ERROR, rsp_last_of_frame && rsp_payload_byte == 8'd0, "error result not marked last")

   `WSFD_ASSERT(a_non_payload_zero, rsp_valid && rsp_result_kind != KIND_PAYLOAD, rsp_payload_byte == 8'd0 && rsp_result_kind != 2'd3, "bad header or error result")

   `WSFD_ASSERT_NEXT(a_halt_after_error, rsp_valid && !rsp_stall && rsp_result_kind == KIND_ERROR, !rsp_valid, "result after framing error")

endmodule

bind websocket_frame_decoder wsfd_checker u_checker (.*);
